// ----- rtl/emag_pkg.sv -----
// ----------------------------------------------------------------------------
// emag_pkg
// Shared types, register codes and constants of the 3x3 edge magnitude core.
// ----------------------------------------------------------------------------
package emag_pkg;

   // Pixel and result widths, row count width, register width and register index width.
   localparam int PIX_W   = 8;
   localparam int ROW_W   = 11;
   localparam int CFG_W   = 12;
   localparam int CSR_IDX_W = 2;

   // Default depth of one line store.
   localparam int DEF_MAX_WIDTH = 2048;

   // Rows per frame are held inside this range.
   localparam logic [CFG_W-1:0] MIN_DIM    = 12'd3;
   localparam logic [CFG_W-1:0] MAX_HEIGHT = 12'd2048;

   // Register values after reset.
   localparam logic [CFG_W-1:0] RST_LINE_WIDTH   = 12'd640;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

   // Saturation level of the result.
   localparam logic [PIX_W-1:0] RES_MAX = 8'd255;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_COMBINE_MODE = 2'd2,
      CSR_KERNEL_SET   = 2'd3
   } csr_idx_type;

   // How the two kernel magnitudes are combined.
   typedef enum logic [1:0] {
      MODE_SUM    = 2'd0,
      MODE_FIRST  = 2'd1,
      MODE_SECOND = 2'd2
   } mode_type;

   // Which pair of kernels is applied.
   typedef enum logic {
      KSET_SOBEL = 1'b0,
      KSET_DIAG  = 1'b1
   } kset_type;

   // 3x3 window, row-major, top row first; element 0 is top left.
   typedef logic [8:0][PIX_W-1:0] win_type;

endpackage

// ----- rtl/emag_line_buf.sv -----
// ----------------------------------------------------------------------------
// emag_line_buf
// Two line stores holding the two rows above the current pixel. Both are
// read at the column of an accepted request, with registered read data, and
// written back when that request leaves the first pipeline stage.
// ----------------------------------------------------------------------------
module emag_line_buf #(
   parameter int MAX_WIDTH = emag_pkg::DEF_MAX_WIDTH,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [emag_pkg::PIX_W-1:0] wr_pix,
   output logic [emag_pkg::PIX_W-1:0] top_ff,
   output logic [emag_pkg::PIX_W-1:0] mid_ff
);

   logic [emag_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [emag_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

   // Read port: data is captured only for an accepted request.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff <= upper_mem[rd_addr];
         mid_ff <= middle_mem[rd_addr];
      end
   end

   // Write port: the middle row moves up and the new pixel becomes the middle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= mid_ff;
         middle_mem[wr_addr] <= wr_pix;
      end
   end

endmodule

// ----- rtl/emag_kernel.sv -----
// ----------------------------------------------------------------------------
// emag_kernel
// Applies the selected kernel pair to a 3x3 window and combines the absolute
// values into one saturated 8-bit edge magnitude.
// ----------------------------------------------------------------------------
module emag_kernel (
   input  emag_pkg::win_type             win,
   input  emag_pkg::kset_type            kernel_set,
   input  emag_pkg::mode_type            combine_mode,
   output logic [emag_pkg::PIX_W-1:0]    edge_res
);

   localparam int SW = 12;

   logic signed [SW-1:0] w [9];
   logic signed [SW-1:0] sum_a;
   logic signed [SW-1:0] sum_b;
   logic [SW-2:0]        abs_a;
   logic [SW-2:0]        abs_b;
   logic [SW-1:0]        mag;

   // Widen every pixel to a signed sum width.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         w[i] = $signed({{(SW-emag_pkg::PIX_W){1'b0}}, win[i]});
      end
   end

   // Constant-weight kernels written as adds and shifts.
   always_comb begin
      case (kernel_set)
         emag_pkg::KSET_SOBEL: begin
            sum_a = (w[6] + (w[7] <<< 1) + w[8]) - (w[0] + (w[1] <<< 1) + w[2]);
            sum_b = (w[2] + (w[5] <<< 1) + w[8]) - (w[0] + (w[3] <<< 1) + w[6]);
         end
         emag_pkg::KSET_DIAG: begin
            sum_a = (w[1] + w[2] + w[5]) - (w[3] + w[6] + w[7]);
            sum_b = (w[5] + w[7] + w[8]) - (w[0] + w[1] + w[3]);
         end
         default: begin
            sum_a = '0;
            sum_b = '0;
         end
      endcase
   end

   // Magnitudes fit in 11 bits since each sum stays within +/-1020.
   always_comb begin
      abs_a = sum_a[SW-1] ? (SW-1)'(-sum_a) : (SW-1)'(sum_a);
      abs_b = sum_b[SW-1] ? (SW-1)'(-sum_b) : (SW-1)'(sum_b);
   end

   // Combine and saturate.
   always_comb begin
      case (combine_mode)
         emag_pkg::MODE_FIRST:  mag = {1'b0, abs_a};
         emag_pkg::MODE_SECOND: mag = {1'b0, abs_b};
         default:               mag = {1'b0, abs_a} + {1'b0, abs_b};
      endcase
      edge_res = (mag > SW'(emag_pkg::RES_MAX)) ? emag_pkg::RES_MAX
                                                : mag[emag_pkg::PIX_W-1:0];
   end

endmodule

// ----- rtl/edge_magnitude_3x3_stream_core.sv -----
// ----------------------------------------------------------------------------
// edge_magnitude_3x3_stream_core
// Streaming 3x3 edge magnitude detector over 8-bit grey pixels in raster
// order, with Sobel and diagonal kernel pairs.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock and returns one result per pixel, in
// order: the edge magnitude at the centre of the 3x3 window that ends at that
// pixel (one row up, one column left), flagged valid once the window lies
// inside the row and frame, and zero otherwise. An accepted request is held
// in the first stage while the line stores are read with registered data,
// then passes to the result register. Throughput is one pixel per cycle
// while the result side keeps up; a stalled result holds the core after one
// more request fills the first stage. The line stores start with no defined
// contents and need no clearing after reset. Change line_width and
// frame_height only between frames, with the core drained.
// ----------------------------------------------------------------------------
module edge_magnitude_3x3_stream_core #(
   parameter int MAX_WIDTH = emag_pkg::DEF_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [emag_pkg::PIX_W-1:0]        req_pixel,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [emag_pkg::PIX_W-1:0]        rsp_edge_res,
   output logic                              rsp_edge_valid,
   // Register write port.
   input  logic                              csr_we,
   input  logic [emag_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [emag_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (AW + 1 > emag_pkg::CFG_W) ? AW + 1 : emag_pkg::CFG_W;
   localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
   localparam int PW = emag_pkg::PIX_W;

   // Configuration registers.
   logic [emag_pkg::CFG_W-1:0] line_width_ff;
   logic [emag_pkg::CFG_W-1:0] frame_height_ff;
   emag_pkg::mode_type         combine_mode_ff;
   emag_pkg::kset_type         kernel_set_ff;

   // Position counters.
   logic [AW-1:0]              col_ff, col_in;
   logic [emag_pkg::ROW_W-1:0] row_ff, row_in;

   // First stage: pixel and position of the request in flight.
   logic                       s1_valid_ff, s1_valid_in;
   logic [PW-1:0]              s1_pix_ff;
   logic [AW-1:0]              s1_col_ff;
   logic                       s1_win_ok_ff;

   // Window columns: three taps two columns back, then three of the previous column.
   logic [PW-1:0]              win_col_ff [6];

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]              rsp_res_ff;
   logic                       rsp_ok_ff;

   logic                       accept;
   logic                       s1_move;
   logic                       rsp_take;
   logic [CMPW-1:0]            width_eff;
   logic [emag_pkg::CFG_W-1:0] height_eff;
   logic                       col_wrap;
   logic                       row_wrap;
   logic                       win_ok;
   logic [PW-1:0]              top_ff;
   logic [PW-1:0]              mid_ff;
   emag_pkg::win_type          win;
   logic [PW-1:0]              kern_res;

   // Handshake: the first stage moves on when the result register is free or its result is taken.
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_take);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= emag_pkg::RST_LINE_WIDTH;
         frame_height_ff <= emag_pkg::RST_FRAME_HEIGHT;
         combine_mode_ff <= emag_pkg::MODE_SUM;
         kernel_set_ff   <= emag_pkg::KSET_SOBEL;
      end else if (csr_we) begin
         case (emag_pkg::csr_idx_type'(csr_index))
            emag_pkg::CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata;
            emag_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            emag_pkg::CSR_COMBINE_MODE:
               combine_mode_ff <= emag_pkg::mode_type'(csr_wdata[1:0]);
            emag_pkg::CSR_KERNEL_SET:
               kernel_set_ff <= emag_pkg::kset_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   // Effective frame size, held inside its legal range.
   always_comb begin
      if (line_width_ff < emag_pkg::MIN_DIM) begin
         width_eff = CMPW'(emag_pkg::MIN_DIM);
      end else if (CMPW'(line_width_ff) > MAX_W_C) begin
         width_eff = MAX_W_C;
      end else begin
         width_eff = CMPW'(line_width_ff);
      end
      if (frame_height_ff < emag_pkg::MIN_DIM) begin
         height_eff = emag_pkg::MIN_DIM;
      end else if (frame_height_ff > emag_pkg::MAX_HEIGHT) begin
         height_eff = emag_pkg::MAX_HEIGHT;
      end else begin
         height_eff = frame_height_ff;
      end
   end

   // Raster position of the next request.
   always_comb begin
      col_wrap = (CMPW'(col_ff) + CMPW'(1)) >= width_eff;
      row_wrap = (emag_pkg::CFG_W'(row_ff) + emag_pkg::CFG_W'(1)) >= height_eff;
      win_ok   = (col_ff >= AW'(2)) && (row_ff >= emag_pkg::ROW_W'(2));
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + emag_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line stores.
   emag_line_buf #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_pix  (s1_pix_ff),
      .top_ff  (top_ff),
      .mid_ff  (mid_ff)
   );

   // First stage.
   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= req_pixel;
         s1_col_ff    <= col_ff;
         s1_win_ok_ff <= win_ok;
      end
   end

   // Window assembly, row-major with the newest column on the right.
   always_comb begin
      win[0] = win_col_ff[0];
      win[1] = win_col_ff[3];
      win[2] = top_ff;
      win[3] = win_col_ff[1];
      win[4] = win_col_ff[4];
      win[5] = mid_ff;
      win[6] = win_col_ff[2];
      win[7] = win_col_ff[5];
      win[8] = s1_pix_ff;
   end

   // Shift the window one column as the request leaves the first stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_col_ff[i] <= '0;
         end
      end else if (s1_move) begin
         win_col_ff[0] <= win_col_ff[3];
         win_col_ff[1] <= win_col_ff[4];
         win_col_ff[2] <= win_col_ff[5];
         win_col_ff[3] <= top_ff;
         win_col_ff[4] <= mid_ff;
         win_col_ff[5] <= s1_pix_ff;
      end
   end

   emag_kernel u_kernel (
      .win          (win),
      .kernel_set   (kernel_set_ff),
      .combine_mode (combine_mode_ff),
      .edge_res     (kern_res)
   );

   // Result register.
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_res_ff <= s1_win_ok_ff ? kern_res : '0;
         rsp_ok_ff  <= s1_win_ok_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_res   = rsp_res_ff;
   assign rsp_edge_valid = rsp_ok_ff;

   // A result outside the frame carries a zero magnitude.
   a_zero_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_res_ff == '0)
      else $error("edge result nonzero outside the frame");

   // Requests are held off only while the first stage is occupied.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with an empty first stage");

   // An accepted request always lands in the first stage.
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request lost");

   // A blocked first stage keeps its position.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("first stage changed while blocked");

   // The column count returns to zero at the end of a row.
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && col_wrap |=> col_ff == '0)
      else $error("column count did not wrap");

endmodule
